@@ hdl/mm_pkg.sv @@
// Shared types and constants for the matrix multiply block.
`timescale 1ns / 1ps

package mm_pkg;

    localparam int ELEM_W = 32;
    localparam int ROW_W  = 3;
    localparam int DIM_W  = 4;
    localparam int CFG_W  = 2;

    localparam logic [DIM_W-1:0] DIM_RST = 4'd8;

    typedef enum logic [1:0] {
        REQ_WR_A    = 2'd0,
        REQ_WR_B    = 2'd1,
        REQ_COMPUTE = 2'd2,
        REQ_NONE    = 2'd3
    } t_req;

    typedef enum logic [CFG_W-1:0] {
        CFG_A_ROWS = 2'd0,
        CFG_A_COLS = 2'd1,
        CFG_B_ROWS = 2'd2,
        CFG_B_COLS = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic valid;
        logic last;
    } t_mac_ctl;

    typedef struct packed {
        logic              valid;
        logic [ELEM_W-1:0] value;
    } t_mac_res;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] lim);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > lim) begin
            r = lim;
        end
        return r;
    endfunction

endpackage

@@ hdl/mm_ifs.sv @@
// Channel interfaces: request input, result output, configuration write.
`timescale 1ns / 1ps

interface mm_in_if;
    import mm_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [1:0]               req_type;
    logic [ROW_W-1:0]         elem_row;
    logic [ROW_W-1:0]         elem_col;
    logic signed [ELEM_W-1:0] elem_value;

    modport source (output valid, req_type, elem_row, elem_col, elem_value, input ready);
    modport sink   (input valid, req_type, elem_row, elem_col, elem_value, output ready);
endinterface

interface mm_out_if;
    import mm_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [ROW_W-1:0]         out_row;
    logic [ROW_W-1:0]         out_col;
    logic signed [ELEM_W-1:0] out_value;
    logic                     out_last;
    logic                     size_error;

    modport source (output valid, out_row, out_col, out_value, out_last, size_error,
                    input ready);
    modport sink   (input valid, out_row, out_col, out_value, out_last, size_error,
                    output ready);
endinterface

interface mm_cfg_if;
    import mm_pkg::*;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] index;
    logic [DIM_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/mm_store.sv @@
// Element store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module mm_store #(
    parameter int DEPTH = 64
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [$clog2(DEPTH)-1:0]          i_waddr,
    input  logic [mm_pkg::ELEM_W-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0]          i_raddr,
    output logic [mm_pkg::ELEM_W-1:0]         o_rdata
);
    import mm_pkg::*;

    logic [ELEM_W-1:0] r_mem [DEPTH];
    logic [ELEM_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/mm_mac.sv @@
// Multiply-accumulate datapath: product, floor shift, wide sum, saturation.
`timescale 1ns / 1ps

module mm_mac #(
    parameter int FRAC_BITS = 16,
    parameter int ACC_W     = 68
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mm_pkg::t_mac_ctl                  i_ctl,
    input  logic signed [mm_pkg::ELEM_W-1:0]  i_a,
    input  logic signed [mm_pkg::ELEM_W-1:0]  i_b,
    output mm_pkg::t_mac_res                  o_res
);
    import mm_pkg::*;

    localparam int PROD_W = 2 * ELEM_W;
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sh0000_0000_7FFF_FFFF);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(64'shFFFF_FFFF_8000_0000);

    t_mac_ctl                  r_p_ctl;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ACC_W-1:0]   n_acc;
    logic signed [ACC_W-1:0]   w_term;
    logic signed [ACC_W-1:0]   w_sum;
    t_mac_res                  r_res;
    logic [ELEM_W-1:0]         w_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_ctl <= '0;
        end else begin
            r_p_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign w_term = ACC_W'(r_prod >>> FRAC_BITS);
    assign w_sum  = r_acc + w_term;

    always_comb begin
        if (w_sum > SAT_HI) begin
            w_sat = SAT_HI[ELEM_W-1:0];
        end else if (w_sum < SAT_LO) begin
            w_sat = SAT_LO[ELEM_W-1:0];
        end else begin
            w_sat = w_sum[ELEM_W-1:0];
        end
    end

    always_comb begin
        n_acc = r_acc;
        if (r_p_ctl.valid) begin
            n_acc = r_p_ctl.last ? '0 : w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_res.valid <= 1'b0;
        end else begin
            r_acc       <= n_acc;
            r_res.valid <= r_p_ctl.valid && r_p_ctl.last;
            if (r_p_ctl.valid && r_p_ctl.last) begin
                r_res.value <= w_sat;
            end
        end
    end

    assign o_res = r_res;

endmodule

@@ hdl/matrix_multiply.sv @@
// Matrix multiply top level: config registers, element stores, sequencer, result register.
`timescale 1ns / 1ps

// Element writes (req 0 for A, 1 for B) are taken one word per cycle while no
// compute is running, and go straight into two single-port-read stores of
// MAX_DIM*MAX_DIM entries. A compute request (req 2) walks C = A * B in
// row-major order; for each result element the sequencer issues a_cols reads
// into the multiply-accumulate pipeline, waits for the pipeline to drain, hands
// the sum into the output register and then holds until that register is free;
// no input word is taken during a compute, and output stalls lengthen it.
// A size mismatch gives one error word at once.
// The stores have no reset: computing on elements never written gives
// arbitrary values.
module matrix_multiply #(
    parameter int MAX_DIM   = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mm_in_if.sink     i_in,
    mm_out_if.source  o_out,
    mm_cfg_if.sink    i_cfg
);
    import mm_pkg::*;

    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ACC_W  = 2 * ELEM_W + $clog2(MAX_DIM) + 1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_HOLD  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [DIM_W-1:0] r_a_rows, r_a_cols, r_b_rows, r_b_cols;
    logic [DIM_W-1:0] w_ar, w_ac, w_br, w_bc;

    logic [IDX_W-1:0] r_i, r_j, r_k, n_i, n_j, n_k;

    logic              r_out_valid, n_out_valid;
    logic [ROW_W-1:0]  r_out_row, r_out_col;
    logic [ELEM_W-1:0] r_out_value;
    logic              r_out_last, r_out_err;
    logic              w_out_load, w_load_err;

    logic       w_in_acc, w_out_acc;
    t_req       w_req;
    logic       w_we_a, w_we_b;
    logic [ADDR_W-1:0] w_waddr, w_raddr_a, w_raddr_b;
    logic [ELEM_W-1:0] w_rdata_a, w_rdata_b;
    logic       w_k_end, w_j_end, w_i_end;

    t_mac_ctl r_rd_ctl;
    t_mac_res w_res;

    // Configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_rows <= DIM_RST;
            r_a_cols <= DIM_RST;
            r_b_rows <= DIM_RST;
            r_b_cols <= DIM_RST;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_A_ROWS: r_a_rows <= i_cfg.data;
                CFG_A_COLS: r_a_cols <= i_cfg.data;
                CFG_B_ROWS: r_b_rows <= i_cfg.data;
                CFG_B_COLS: r_b_cols <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign w_ar = eff_dim(r_a_rows, DIM_W'(MAX_DIM));
    assign w_ac = eff_dim(r_a_cols, DIM_W'(MAX_DIM));
    assign w_br = eff_dim(r_b_rows, DIM_W'(MAX_DIM));
    assign w_bc = eff_dim(r_b_cols, DIM_W'(MAX_DIM));

    // Input side
    assign w_req       = t_req'(i_in.req_type);
    assign i_in.ready  = (r_state == ST_IDLE) && (!r_out_valid || w_req != REQ_COMPUTE);
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign w_out_acc   = r_out_valid && o_out.ready;

    assign w_we_a = w_in_acc && (w_req == REQ_WR_A)
                    && (DIM_W'(i_in.elem_row) < w_ar) && (DIM_W'(i_in.elem_col) < w_ac);
    assign w_we_b = w_in_acc && (w_req == REQ_WR_B)
                    && (DIM_W'(i_in.elem_row) < w_br) && (DIM_W'(i_in.elem_col) < w_bc);

    assign w_waddr = ADDR_W'(ADDR_W'(IDX_W'(i_in.elem_row)) * ADDR_W'(MAX_DIM)
                             + ADDR_W'(IDX_W'(i_in.elem_col)));

    assign w_raddr_a = ADDR_W'(ADDR_W'(r_i) * ADDR_W'(MAX_DIM) + ADDR_W'(r_k));
    assign w_raddr_b = ADDR_W'(ADDR_W'(r_k) * ADDR_W'(MAX_DIM) + ADDR_W'(r_j));

    mm_store #(.DEPTH(DEPTH)) u_store_a (
        .i_clk   (i_clk),
        .i_we    (w_we_a),
        .i_waddr (w_waddr),
        .i_wdata (i_in.elem_value),
        .i_raddr (w_raddr_a),
        .o_rdata (w_rdata_a)
    );

    mm_store #(.DEPTH(DEPTH)) u_store_b (
        .i_clk   (i_clk),
        .i_we    (w_we_b),
        .i_waddr (w_waddr),
        .i_wdata (i_in.elem_value),
        .i_raddr (w_raddr_b),
        .o_rdata (w_rdata_b)
    );

    // Sequencer
    assign w_k_end = (DIM_W'(r_k) == w_ac - DIM_W'(1));
    assign w_j_end = (DIM_W'(r_j) == w_bc - DIM_W'(1));
    assign w_i_end = (DIM_W'(r_i) == w_ar - DIM_W'(1));

    always_comb begin
        n_state    = r_state;
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        w_out_load = 1'b0;
        w_load_err = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && w_req == REQ_COMPUTE) begin
                    if (w_ac != w_br) begin
                        w_out_load = 1'b1;
                        w_load_err = 1'b1;
                    end else begin
                        n_state = ST_ISSUE;
                        n_i     = '0;
                        n_j     = '0;
                        n_k     = '0;
                    end
                end
            end
            ST_ISSUE: begin
                if (w_k_end) begin
                    n_k     = '0;
                    n_state = ST_DRAIN;
                end else begin
                    n_k = r_k + IDX_W'(1);
                end
            end
            ST_DRAIN: begin
                if (w_res.valid) begin
                    w_out_load = 1'b1;
                    n_state    = (w_i_end && w_j_end) ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (!r_out_valid || w_out_acc) begin
                    n_state = ST_ISSUE;
                    if (w_j_end) begin
                        n_j = '0;
                        n_i = r_i + IDX_W'(1);
                    end else begin
                        n_j = r_j + IDX_W'(1);
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_rd_ctl <= '0;
        end else begin
            r_state        <= n_state;
            r_i            <= n_i;
            r_j            <= n_j;
            r_k            <= n_k;
            r_rd_ctl.valid <= (r_state == ST_ISSUE);
            r_rd_ctl.last  <= w_k_end;
        end
    end

    mm_mac #(.FRAC_BITS(FRAC_BITS), .ACC_W(ACC_W)) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_rd_ctl),
        .i_a     (w_rdata_a),
        .i_b     (w_rdata_b),
        .o_res   (w_res)
    );

    // Result register
    always_comb begin
        n_out_valid = r_out_valid && !w_out_acc;
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            if (w_load_err) begin
                r_out_row   <= '0;
                r_out_col   <= '0;
                r_out_value <= '0;
                r_out_last  <= 1'b1;
                r_out_err   <= 1'b1;
            end else begin
                r_out_row   <= ROW_W'(r_i);
                r_out_col   <= ROW_W'(r_j);
                r_out_value <= w_res.value;
                r_out_last  <= w_i_end && w_j_end;
                r_out_err   <= 1'b0;
            end
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.out_row    = r_out_row;
    assign o_out.out_col    = r_out_col;
    assign o_out.out_value  = r_out_value;
    assign o_out.out_last   = r_out_last;
    assign o_out.size_error = r_out_err;

endmodule
